[design/csx_pkg.sv]
`timescale 1ns / 1ps
// Package for the categorical sampler: widths, constants, the generator step
// and the coin channel type. Used by csx_coin_gen and the top level.
package csx_pkg;

    localparam int unsigned MAX_ITEMS      = 131072;
    localparam int unsigned PROB_FRAC_BITS = 24;

    localparam int unsigned PROB_W  = 25;
    localparam int unsigned IDX_W   = 17;
    localparam int unsigned COIN_W  = 24;
    localparam int unsigned SUM_W   = 42;
    localparam int unsigned STATE_W = 64;

    localparam int unsigned IDX_FIELD_MAX = (1 << IDX_W) - 1;
    localparam int unsigned IDX_CAP_INT   =
        (MAX_ITEMS - 1 > IDX_FIELD_MAX) ? IDX_FIELD_MAX : MAX_ITEMS - 1;
    localparam logic [IDX_W-1:0] IDX_CAP  = IDX_W'(IDX_CAP_INT);

    localparam int unsigned COIN_SHL = (PROB_FRAC_BITS >= COIN_W) ? PROB_FRAC_BITS - COIN_W : 0;
    localparam int unsigned COIN_SHR = (PROB_FRAC_BITS >= COIN_W) ? 0 : COIN_W - PROB_FRAC_BITS;

    localparam logic [31:0] MULT_LO = 32'h4F6CDD1D;
    localparam logic [31:0] MULT_HI = 32'h2545F491;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic              valid;
        logic [COIN_W-1:0] coin;
    } coin_status_t;

    function automatic logic [STATE_W-1:0] xorshift_step(input logic [STATE_W-1:0] s_in);
        logic [STATE_W-1:0] s;
        s = s_in;
        s = s ^ (s >> 12);
        s = s ^ (s << 25);
        s = s ^ (s >> 27);
        return s;
    endfunction

endpackage

[design/categorical_sampler_xorshift_core.sv]
`timescale 1ns / 1ps
// Categorical sampler top level: accumulates a streamed probability vector and
// picks an index by inverse CDF. Depends on csx_pkg and csx_coin_gen.
//
// Usage: probabilities arrive on the input channel (probability, last_item,
// in_valid/in_ready), one element per request, Q1.24 unsigned. On the first
// element of a vector a coin drawn from a xorshift64* generator is taken. On
// the element flagged last_item one result request appears on the output channel
// (chosen_index, fell_through, out_valid/out_ready) in the next cycle. Throughput
// is one element per cycle unless stalled; the coin multiplier runs ahead in a
// two-stage pipeline feeding a four-entry coin queue, so coins keep pace with
// back-to-back one-element vectors. After reset or a seed write the first coin
// passes st_a, the products and the queue, and in_ready stays low on a vector's
// first element until then. When the receiver stalls, the result stays in the
// output register and in_ready drops until it is taken. Reset loads the generator
// with seed 1 and clears all vector state; seed_wr_en with seed reloads the
// generator and discards queued coins, keeping the coin of a vector in progress.
module categorical_sampler_xorshift_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seed_wr_en,
    input  logic [csx_pkg::STATE_W-1:0]   seed,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [csx_pkg::PROB_W-1:0]    probability,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csx_pkg::IDX_W-1:0]     chosen_index,
    output logic                          fell_through
);

    csx_pkg::coin_status_t        coin_st;
    logic                         pop;
    logic                         in_fire;
    logic                         out_free;
    logic                         first_item;

    logic [csx_pkg::COIN_W-1:0]   coin_reg;
    logic [csx_pkg::SUM_W-1:0]    sum_reg;
    logic [csx_pkg::IDX_W-1:0]    pos_reg;
    logic                         hit_reg;
    logic [csx_pkg::IDX_W-1:0]    hit_idx_reg;
    logic                         out_valid_reg;
    logic [csx_pkg::IDX_W-1:0]    out_idx_reg;
    logic                         out_fell_reg;

    logic [csx_pkg::COIN_W-1:0]   coin_cur;
    logic [csx_pkg::SUM_W:0]      sum_wide;
    logic [csx_pkg::SUM_W-1:0]    sum_next;
    logic [csx_pkg::SUM_W-1:0]    coin_aligned;
    logic                         hit_now;
    logic                         hit_next;
    logic [csx_pkg::IDX_W-1:0]    hit_idx_next;

    csx_coin_gen u_coin_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_wr_en (seed_wr_en),
        .seed       (seed),
        .pop        (pop),
        .coin_st    (coin_st)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign first_item = (pos_reg == '0);
    assign in_ready   = out_free && (!first_item || coin_st.valid);
    assign in_fire    = in_valid && in_ready;
    assign pop        = in_fire && first_item;

    assign coin_cur = first_item ? coin_st.coin : coin_reg;
    assign sum_wide = {1'b0, sum_reg} + (csx_pkg::SUM_W+1)'(probability);
    assign sum_next = sum_wide[csx_pkg::SUM_W] ? '1 : sum_wide[csx_pkg::SUM_W-1:0];
    assign coin_aligned = (csx_pkg::SUM_W'(coin_cur) << csx_pkg::COIN_SHL) >> csx_pkg::COIN_SHR;
    assign hit_now      = !hit_reg && (coin_aligned < sum_next);
    assign hit_next     = hit_reg || hit_now;
    assign hit_idx_next = hit_now ? pos_reg : hit_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_reg      <= '0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && last_item)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire)
            begin
                if (first_item)
                begin
                    coin_reg <= coin_st.coin;
                end
                if (last_item)
                begin
                    sum_reg       <= '0;
                    pos_reg       <= '0;
                    hit_reg       <= 1'b0;
                    hit_idx_reg   <= '0;
                end
                else
                begin
                    sum_reg     <= sum_next;
                    hit_reg     <= hit_next;
                    hit_idx_reg <= hit_idx_next;
                    if (pos_reg < csx_pkg::IDX_CAP)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last_item)
        begin
            out_idx_reg  <= hit_next ? hit_idx_next : pos_reg;
            out_fell_reg <= !hit_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = out_idx_reg;
    assign fell_through = out_fell_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_item |=> out_valid_reg)
        else $error("last element did not produce a result");

    a_last_clears_vector: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_item |=> (pos_reg == '0) && (sum_reg == '0) && !hit_reg)
        else $error("vector state not cleared after last element");

    a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= csx_pkg::IDX_CAP)
        else $error("position beyond index cap");

    a_hit_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> hit_idx_reg <= pos_reg)
        else $error("recorded hit index ahead of position");

endmodule

[design/csx_coin_gen.sv]
`timescale 1ns / 1ps
// Coin generator: steps the xorshift64* state ahead of use, multiplies in
// two stages and queues coins in a small FIFO. Depends on csx_pkg.
module csx_coin_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           seed_wr_en,
    input  logic [csx_pkg::STATE_W-1:0]    seed,
    input  logic                           pop,
    output csx_pkg::coin_status_t          coin_st
);

    logic [csx_pkg::STATE_W-1:0] gen_state_reg;
    logic [csx_pkg::STATE_W-1:0] st_a_reg;
    logic                        va_reg;
    logic [63:0]                 p0_reg;
    logic [31:0]                 p1_reg;
    logic [31:0]                 p2_reg;
    logic                        vb_reg;
    logic [csx_pkg::COIN_W-1:0]  fifo_mem [csx_pkg::FIFO_DEPTH];
    logic [csx_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [csx_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [csx_pkg::CNT_W-1:0]   count_reg;

    logic [csx_pkg::CNT_W:0]     occupancy;
    logic                        issue;
    logic [csx_pkg::STATE_W-1:0] gen_state_next;
    logic [31:0]                 mixed;
    logic [csx_pkg::CNT_W-1:0]   count_next;

    assign occupancy = (csx_pkg::CNT_W+1)'(count_reg) + (csx_pkg::CNT_W+1)'(va_reg)
                     + (csx_pkg::CNT_W+1)'(vb_reg);
    assign issue = occupancy < ((csx_pkg::CNT_W+1)'(csx_pkg::FIFO_DEPTH)
                              + (csx_pkg::CNT_W+1)'(pop));
    assign gen_state_next = csx_pkg::xorshift_step(gen_state_reg);
    assign mixed = p0_reg[63:32] + p1_reg + p2_reg;
    assign count_next = count_reg + csx_pkg::CNT_W'(vb_reg) - csx_pkg::CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= csx_pkg::STATE_W'(1);
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else if (seed_wr_en)
        begin
            gen_state_reg <= seed;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (issue)
            begin
                gen_state_reg <= gen_state_next;
            end
            va_reg    <= issue;
            vb_reg    <= va_reg;
            count_reg <= count_next;
            if (vb_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            st_a_reg <= gen_state_next;
        end
        p0_reg <= st_a_reg[31:0] * csx_pkg::MULT_LO;
        p1_reg <= 32'(st_a_reg[63:32] * csx_pkg::MULT_LO);
        p2_reg <= 32'(st_a_reg[31:0] * csx_pkg::MULT_HI);
        if (vb_reg)
        begin
            fifo_mem[wr_ptr_reg] <= mixed[31:8];
        end
    end

    assign coin_st.valid = (count_reg != '0);
    assign coin_st.coin  = fifo_mem[rd_ptr_reg];

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (csx_pkg::CNT_W+1)'(csx_pkg::FIFO_DEPTH))
        else $error("coin queue overfilled");

    a_pop_needs_coin: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("coin taken from an empty queue");

    a_seed_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr_en |=> (count_reg == '0) && !va_reg && !vb_reg)
        else $error("seed write did not flush queued coins");

endmodule
